@@ rtl/core/b32d_pkg.sv @@
// Package for the base32 string decoder: payload structs, status codes,
// the symbol decode function and the group size table.
// No dependencies; every module of the decoder imports it.
`default_nettype none

package b32d_pkg;

   localparam int GROUP_CHARS         = 8;
   localparam int GROUP_BYTES         = 5;
   localparam int VALUE_WIDTH         = 5;
   localparam int FILL_WIDTH          = $clog2(GROUP_CHARS);
   localparam int NEEDS_WIDTH         = 3;
   localparam int COUNT_WIDTH         = 17;
   localparam int POSITION_WIDTH      = 16;
   localparam int LIMIT_WIDTH         = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [LIMIT_WIDTH-1:0]    LIMIT_RESET  = 16'hFFFF;
   localparam logic [POSITION_WIDTH-1:0] POSITION_MAX = 16'hFFFF;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_DIGIT_2 = 8'h32;
   localparam logic [7:0] CHAR_DIGIT_7 = 8'h37;
   localparam logic [7:0] DIGIT_OFFSET = 8'd26;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_CHAR = 2'd1,
      STATUS_LIMIT    = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       final_req;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]                data_byte;
      logic                      byte_valid;
      status_type                status;
      logic [POSITION_WIDTH-1:0] error_position;
      logic [COUNT_WIDTH-1:0]    total_length;
      logic                      last;
   } rsp_payload_type;

   // One unit of work for the back end: either a decoded group or a report.
   typedef struct packed {
      logic [0:GROUP_BYTES-1][7:0] group;
      logic [NEEDS_WIDTH-1:0]      needs;
      status_type                  status;
      logic [POSITION_WIDTH-1:0]   error_position;
      logic [COUNT_WIDTH-1:0]      total;
      logic                        last;
   } job_type;

   typedef struct packed {
      logic                   valid;
      logic [VALUE_WIDTH-1:0] value;
   } symbol_code_type;

   function automatic symbol_code_type decode_symbol(input logic [7:0] sym);
      symbol_code_type code;
      code.valid = 1'b1;
      code.value = '0;
      if (sym >= CHAR_UPPER_A && sym <= CHAR_UPPER_Z) begin
         code.value = VALUE_WIDTH'(sym - CHAR_UPPER_A);
      end else if (sym >= CHAR_DIGIT_2 && sym <= CHAR_DIGIT_7) begin
         code.value = VALUE_WIDTH'(sym - CHAR_DIGIT_2 + DIGIT_OFFSET);
      end else begin
         code.valid = 1'b0;
      end
      return code;
   endfunction

   function automatic logic [NEEDS_WIDTH-1:0] group_byte_count(
      input logic [FILL_WIDTH:0] fill);
      logic [NEEDS_WIDTH-1:0] needs;
      unique case (fill)
         4'd8:    needs = 3'd5;
         4'd7:    needs = 3'd4;
         4'd5:    needs = 3'd3;
         4'd4:    needs = 3'd2;
         4'd2:    needs = 3'd1;
         default: needs = 3'd0;
      endcase
      return needs;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/base32_string_decoder_unit.sv @@
// Top level of the base32 string decoder: front end, job queue, back end.
// Depends on b32d_pkg, b32d_front, b32d_queue and b32d_back.
//
//   Channel  Direction  Handshake                         Moves
//   req      in         req_valid / req_stall             one character per request
//   rsp      out        rsp_valid / rsp_stall             one byte or report per request
//   csr      in         csr_write_enable / csr_write_data max_output, no read-back
//
// The front end accepts one character per cycle while the queue is not full and
// does the lookup, group fill and limit check in that cycle. The back end emits
// one result per cycle while rsp_stall is low, so a full group of eight
// characters yields its five bytes in order; the bytes of a group pass through
// the queue slot and then the output register.
// The queue holds QueueDepth jobs; req_stall is high only while it is full.
// Reset is synchronous and clears the string state and sets max_output to 65535.
`default_nettype none

module base32_string_decoder_unit #(
   parameter int QueueDepth = b32d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire b32d_pkg::req_payload_type         req_payload,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output b32d_pkg::rsp_payload_type              rsp_payload,
   input  wire logic                              csr_write_enable,
   input  wire logic [b32d_pkg::LIMIT_WIDTH-1:0]  csr_write_data
);
   import b32d_pkg::*;

   logic    q_full;
   logic    q_valid;
   logic    push;
   logic    pop;
   job_type push_job;
   job_type head_job;

   b32d_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_payload      (req_payload),
      .req_stall        (req_stall),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_full           (q_full),
      .push             (push),
      .push_job         (push_job)
   );

   b32d_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (q_full),
      .valid    (q_valid),
      .head     (head_job)
   );

   b32d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .head        (head_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("job pushed into a full queue");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("job popped from an empty queue");

   a_byte_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.byte_valid |->
         rsp_payload.status == STATUS_OK && rsp_payload.error_position == '0)
      else $error("decoded byte carries an error report");

   a_report_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.byte_valid |-> rsp_payload.last)
      else $error("result without a byte does not end the string");

endmodule

`default_nettype wire

@@ rtl/core/b32d_front.sv @@
// Front end of the base32 string decoder: accepts characters, decodes them,
// builds groups, checks the byte limit and pushes jobs to the queue.
// Depends on b32d_pkg.
`default_nettype none

module b32d_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire b32d_pkg::req_payload_type     req_payload,
   output logic                               req_stall,
   input  wire logic                          csr_write_enable,
   input  wire logic [b32d_pkg::LIMIT_WIDTH-1:0] csr_write_data,
   input  wire logic                          q_full,
   output logic                               push,
   output b32d_pkg::job_type                  push_job
);
   import b32d_pkg::*;

   logic [0:GROUP_CHARS-1][VALUE_WIDTH-1:0] values_ff, values_in;
   logic [FILL_WIDTH-1:0]     fill_ff, fill_in;
   logic [COUNT_WIDTH-1:0]    bytes_ff, bytes_in;
   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic                      skip_ff, skip_in;
   logic [LIMIT_WIDTH-1:0]    max_ff, max_in;

   logic                      accept;
   symbol_code_type           code;
   logic [POSITION_WIDTH-1:0] pos_inc;
   logic [FILL_WIDTH:0]       fill_next;
   logic [NEEDS_WIDTH-1:0]    needs;
   logic [COUNT_WIDTH-1:0]    sum;
   logic                      over;
   logic                      fin;

   assign req_stall = q_full;

   always_comb begin
      accept    = req_valid && !q_full;
      fin       = req_payload.final_req;
      code      = decode_symbol(req_payload.symbol);
      pos_inc   = (pos_ff == POSITION_MAX) ? pos_ff : pos_ff + 16'd1;
      values_in = values_ff;
      values_in[fill_ff] = code.value;
      fill_next = {1'b0, fill_ff} + 4'd1;
      needs     = group_byte_count(fill_next);
      sum       = bytes_ff + COUNT_WIDTH'(needs);
      over      = sum > {1'b0, max_ff};
      max_in    = csr_write_enable ? csr_write_data : max_ff;

      fill_in  = fill_ff;
      bytes_in = bytes_ff;
      pos_in   = pos_ff;
      skip_in  = skip_ff;

      push                    = 1'b0;
      push_job.group          = values_in;
      push_job.needs          = '0;
      push_job.status         = STATUS_OK;
      push_job.error_position = '0;
      push_job.total          = bytes_ff;
      push_job.last           = 1'b1;

      if (accept && !skip_ff) begin
         pos_in = pos_inc;
         if (!code.valid) begin
            push                    = 1'b1;
            push_job.status         = STATUS_BAD_CHAR;
            push_job.error_position = pos_inc;
            skip_in                 = 1'b1;
         end else if (fill_next < 4'(GROUP_CHARS) && !fin) begin
            fill_in = fill_next[FILL_WIDTH-1:0];
         end else if (over) begin
            push            = 1'b1;
            push_job.status = STATUS_LIMIT;
            push_job.total  = sum;
            skip_in         = 1'b1;
         end else begin
            push           = 1'b1;
            push_job.needs = needs;
            push_job.last  = fin;
            bytes_in       = sum;
            fill_in        = '0;
         end
      end

      // The final character of a string clears all string state.
      if (accept && fin) begin
         fill_in  = '0;
         bytes_in = '0;
         pos_in   = '0;
         skip_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         bytes_ff <= '0;
         pos_ff   <= '0;
         skip_ff  <= 1'b0;
         max_ff   <= LIMIT_RESET;
      end else begin
         fill_ff  <= fill_in;
         bytes_ff <= bytes_in;
         pos_ff   <= pos_in;
         skip_ff  <= skip_in;
         max_ff   <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         values_ff <= values_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/b32d_queue.sv @@
// Job queue between the front and back ends of the base32 string decoder.
// Register-based circular buffer; depends on b32d_pkg.
`default_nettype none

module b32d_queue #(
   parameter int Depth = b32d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire b32d_pkg::job_type push_job,
   input  wire logic              pop,
   output logic                   full,
   output logic                   valid,
   output b32d_pkg::job_type      head
);
   import b32d_pkg::*;

   localparam int PtrWidth   = $clog2(Depth);
   localparam int CountWidth = $clog2(Depth + 1);

   job_type                 slots_ff [Depth];
   logic [PtrWidth-1:0]     head_ff, head_in;
   logic [PtrWidth-1:0]     tail_ff, tail_in;
   logic [CountWidth-1:0]   count_ff, count_in;

   assign full  = count_ff == CountWidth'(Depth);
   assign valid = count_ff != '0;
   assign head  = slots_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PtrWidth'(Depth - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == PtrWidth'(Depth - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[tail_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/b32d_back.sv @@
// Back end of the base32 string decoder: expands each queued job into one
// result per cycle and holds it in the output register until taken.
// Depends on b32d_pkg.
`default_nettype none

module b32d_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire b32d_pkg::job_type     head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output b32d_pkg::rsp_payload_type  rsp_payload
);
   import b32d_pkg::*;

   logic [NEEDS_WIDTH-1:0] idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;
   logic                   load;
   logic                   last_byte;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_comb begin
      load      = q_valid && (!rsp_valid_ff || !rsp_stall);
      last_byte = (head.needs == '0) || (idx_ff + 3'd1 == head.needs);
      pop       = load && last_byte;

      if (head.needs == '0) begin
         rsp_data_in.data_byte      = '0;
         rsp_data_in.byte_valid     = 1'b0;
         rsp_data_in.status         = head.status;
         rsp_data_in.error_position = head.error_position;
         rsp_data_in.total_length   = head.total;
         rsp_data_in.last           = 1'b1;
      end else begin
         rsp_data_in.data_byte      = head.group[idx_ff];
         rsp_data_in.byte_valid     = 1'b1;
         rsp_data_in.status         = STATUS_OK;
         rsp_data_in.error_position = '0;
         rsp_data_in.total_length   = head.total + COUNT_WIDTH'(idx_ff) + 17'd1;
         rsp_data_in.last           = head.last && last_byte;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
         idx_in       = last_byte ? '0 : idx_ff + 3'd1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         idx_in       = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire
